/* sv/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character codes and the alphabet lookup for the Base64
// decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned KIND_W  = 2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  // Digit value of '+', used when a leading '+' turns out to be data
  localparam logic [DIGIT_W-1:0] DIGIT_PLUS = 6'd62;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // Progress through the optional "+ " prefix
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_PLUS  = 2'd1,
    PH_BODY  = 2'd2
  } phase_e;

  // Results caused by one character: up to three bytes, then done or error
  typedef struct packed {
    logic [2:0][CHAR_W-1:0] bytes;
    logic [1:0]             nbytes;
    logic                   has_tail;
    kind_e                  tail_kind;
    logic [LEN_W-1:0]       length;
  } bundle_t;

  // Returns {valid, value} for one character of the alphabet
  function automatic logic [DIGIT_W:0] digit_lookup(logic [CHAR_W-1:0] c);
    logic [DIGIT_W:0] res;
    res = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      res = {1'b1, DIGIT_W'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      res = {1'b1, DIGIT_W'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, DIGIT_W'(c - 8'h30 + 8'd52)};
    end else if (c == CH_PLUS) begin
      res = {1'b1, DIGIT_PLUS};
    end else if (c == 8'h2F) begin
      res = {1'b1, 6'd63};
    end
    return res;
  endfunction

endpackage

/* sv/b64d_if.sv */
// ----------------------------------------------------------------------------
// b64d_in_if / b64d_out_if
// Valid/ready channels for encoded characters in and decoded results out.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_req;

  modport source (output valid, output char_code, output start_req, input ready);
  modport sink   (input valid, input char_code, input start_req, output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] length;
  logic        last;

  modport source (output valid, output kind, output data_byte, output length,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input length,
                  input last, output ready);
endinterface

/* sv/base64_decoder.sv */
// ----------------------------------------------------------------------------
// base64_decoder
// Streaming Base64 decoder, one encoded character per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one character per beat; start_req marks the first character
//   of a message and abandons any message in progress. A leading "+ " is
//   skipped. Each character is checked on arrival; a full group of four
//   sends its one to three bytes on out_o as data beats. Newline at a group
//   boundary, NUL there once a group has completed, or '=' in fourth place
//   ends the message with a done beat carrying the byte count (saturating
//   at 65535). A bad character gives one error beat; later characters are
//   dropped until the next start. The last beat of a character has last set.
// Timing:
//   The results of a character are registered into the queue before they
//   show. One character is taken every cycle; results leave one per cycle,
//   while the receiver is ready, from a two-entry queue of per-character
//   result bundles, so a character is stalled only when both entries are
//   occupied. One character yields at most three beats (three bytes, or two
//   bytes and done when '=' ends the group).
// Reset:
//   Clears the queue and leaves the decoder waiting for a start. When the
//   receiver stalls, the head beat holds and the queue fills, then in_i.ready
//   drops.
// ----------------------------------------------------------------------------
module base64_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  b64d_in_if.sink    in_i,
  b64d_out_if.source out_o
);
  import b64d_pkg::*;

  // Decoder state
  logic [1:0]                  pos_q, pos_d;
  logic [2:0][DIGIT_W-1:0]     held_q, held_d;
  logic                        pad3_q, pad3_d;
  phase_e                      phase_q, phase_d;
  logic                        first_q, first_d;
  logic                        halted_q, halted_d;
  logic [LEN_W-1:0]            count_q, count_d;

  // Result queue: slot 0 is the head
  bundle_t                     slot0_q, slot1_q, slot0_d, slot1_d;
  logic                        v0_q, v1_q, v0_d, v1_d;
  logic [1:0]                  idx_q, idx_d;

  logic                        in_fire;
  logic                        out_fire;
  logic                        pop;
  logic                        push;
  logic                        take;
  logic                        pad4;
  logic [DIGIT_W:0]            dig;
  logic [LEN_W:0]              sum;
  bundle_t                     bnd;
  logic [2:0]                  head_nres;
  logic                        head_is_data;
  logic [CHAR_W-1:0]           head_byte;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = !v1_q;
  assign dig      = digit_lookup(in_i.char_code);
  assign pad4     = (in_i.char_code == CH_PAD);

  // Character decode: next state and the bundle of results
  always_comb begin
    pos_d    = pos_q;
    held_d   = held_q;
    pad3_d   = pad3_q;
    phase_d  = phase_q;
    first_d  = first_q;
    halted_d = halted_q;
    count_d  = count_q;
    take     = 1'b0;
    sum      = '0;
    bnd      = '0;
    bnd.tail_kind = KIND_DONE;

    // start clears the message
    if (in_i.start_req) begin
      pos_d    = '0;
      held_d   = '0;
      pad3_d   = 1'b0;
      phase_d  = PH_START;
      first_d  = 1'b1;
      count_d  = '0;
      halted_d = 1'b0;
    end

    // optional "+ " prefix
    if (!halted_d) begin
      unique case (phase_d)
        PH_START: begin
          if (in_i.char_code == CH_PLUS) begin
            phase_d = PH_PLUS;
          end else begin
            phase_d = PH_BODY;
            take    = 1'b1;
          end
        end
        PH_PLUS: begin
          phase_d = PH_BODY;
          if (in_i.char_code != CH_SPACE) begin
            held_d[0] = DIGIT_PLUS;
            pos_d     = 2'd1;
            take      = 1'b1;
          end
        end
        default: take = 1'b1;
      endcase
    end

    // group position
    if (take) begin
      unique case (pos_d)
        2'd0: begin
          if (in_i.char_code == CH_LF || (in_i.char_code == CH_NUL && !first_d)) begin
            bnd.has_tail  = 1'b1;
            bnd.tail_kind = KIND_DONE;
            bnd.length    = count_d;
            halted_d      = 1'b1;
          end else if (!dig[DIGIT_W]) begin
            bnd.has_tail  = 1'b1;
            bnd.tail_kind = KIND_ERR;
            halted_d      = 1'b1;
          end else begin
            held_d[0] = dig[DIGIT_W-1:0];
            pos_d     = 2'd1;
          end
        end
        2'd1: begin
          if (!dig[DIGIT_W]) begin
            bnd.has_tail  = 1'b1;
            bnd.tail_kind = KIND_ERR;
            halted_d      = 1'b1;
          end else begin
            held_d[1] = dig[DIGIT_W-1:0];
            pos_d     = 2'd2;
          end
        end
        2'd2: begin
          if (pad4) begin
            pad3_d    = 1'b1;
            held_d[2] = '0;
            pos_d     = 2'd3;
          end else if (!dig[DIGIT_W]) begin
            bnd.has_tail  = 1'b1;
            bnd.tail_kind = KIND_ERR;
            halted_d      = 1'b1;
          end else begin
            pad3_d    = 1'b0;
            held_d[2] = dig[DIGIT_W-1:0];
            pos_d     = 2'd3;
          end
        end
        default: begin
          if (!pad4 && !dig[DIGIT_W]) begin
            bnd.has_tail  = 1'b1;
            bnd.tail_kind = KIND_ERR;
            halted_d      = 1'b1;
          end else begin
            bnd.bytes[0] = {held_d[0], held_d[1][5:4]};
            bnd.bytes[1] = {held_d[1][3:0], held_d[2][5:2]};
            bnd.bytes[2] = {held_d[2][1:0], dig[DIGIT_W-1:0]};
            bnd.nbytes   = pad3_d ? 2'd1 : (pad4 ? 2'd2 : 2'd3);
            sum          = {1'b0, count_d} + (LEN_W+1)'(bnd.nbytes);
            count_d      = sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
            pos_d        = '0;
            pad3_d       = 1'b0;
            first_d      = 1'b0;
            if (pad4) begin
              bnd.has_tail  = 1'b1;
              bnd.tail_kind = KIND_DONE;
              bnd.length    = count_d;
              halted_d      = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      held_q   <= '0;
      pad3_q   <= 1'b0;
      phase_q  <= PH_START;
      first_q  <= 1'b1;
      halted_q <= 1'b1;
      count_q  <= '0;
    end else if (in_fire) begin
      pos_q    <= pos_d;
      held_q   <= held_d;
      pad3_q   <= pad3_d;
      phase_q  <= phase_d;
      first_q  <= first_d;
      halted_q <= halted_d;
      count_q  <= count_d;
    end
  end

  // Head bundle view
  assign head_nres    = {1'b0, slot0_q.nbytes} + {2'b00, slot0_q.has_tail};
  assign head_is_data = (idx_q < slot0_q.nbytes);

  always_comb begin
    unique case (idx_q)
      2'd0:    head_byte = slot0_q.bytes[0];
      2'd1:    head_byte = slot0_q.bytes[1];
      2'd2:    head_byte = slot0_q.bytes[2];
      default: head_byte = '0;
    endcase
  end

  assign out_o.valid     = v0_q;
  assign out_o.kind      = head_is_data ? KIND_DATA : slot0_q.tail_kind;
  assign out_o.data_byte = head_is_data ? head_byte : '0;
  assign out_o.length    = (!head_is_data && slot0_q.tail_kind == KIND_DONE) ?
                           slot0_q.length : '0;
  assign out_o.last      = ({1'b0, idx_q} + 3'd1 == head_nres);

  assign out_fire = out_o.valid && out_o.ready;
  assign pop      = out_fire && out_o.last;
  assign push     = in_fire && (bnd.nbytes != 2'd0 || bnd.has_tail);

  // Queue next state: pop shifts, push fills the first free slot
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    v0_d    = v0_q;
    v1_d    = v1_q;
    idx_d   = idx_q;
    if (pop) begin
      slot0_d = slot1_q;
      v0_d    = v1_q;
      v1_d    = 1'b0;
      idx_d   = '0;
    end else if (out_fire) begin
      idx_d = idx_q + 2'd1;
    end
    if (push) begin
      if (!v0_d) begin
        slot0_d = bnd;
        v0_d    = 1'b1;
      end else begin
        slot1_d = bnd;
        v1_d    = 1'b1;
      end
    end
  end

  // Queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      v0_q  <= v0_d;
      v1_q  <= v1_d;
      idx_q <= idx_d;
    end
  end

  // Queue payload
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

/* sv/b64d_checker.sv */
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [7:0]  out_data_byte_i,
  input logic [15:0] out_length_i,
  input logic        out_last_i
);
  import b64d_pkg::*;

  // A stalled beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
      $stable(out_data_byte_i) && $stable(out_length_i) && $stable(out_last_i))
    else $error("result beat changed while stalled");

  // Done and error always close the results of a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_DONE || out_kind_i == KIND_ERR) |-> out_last_i)
    else $error("done or error beat without last");

  // Only data beats carry a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != KIND_DATA |-> out_data_byte_i == '0)
    else $error("byte on a non-data beat");

  // Only done beats carry a length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != KIND_DONE |-> out_length_i == '0)
    else $error("length on a non-done beat");

endmodule

bind base64_decoder b64d_checker u_b64d_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.kind),
  .out_data_byte_i(out_o.data_byte),
  .out_length_i   (out_o.length),
  .out_last_i     (out_o.last)
);

/* tb/sv/tb_base64_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_decoder
// Self-checking bench for the streaming Base64 decoder. A short table of
// directed characters comes first. Random messages with random bursts of
// valid and ready gaps follow, and a gap-free message of full groups comes
// last. Every result beat is checked field by field against a decoder model
// kept inside the bench, or against the row's own expectation for typed rows.
// ----------------------------------------------------------------------------
module tb_base64_decoder;
  import b64d_pkg::*;

  localparam int    QUIET_LIMIT  = 2000;  // cycles without any beat
  localparam int    HOLD_CYCLES  = 400;   // long sink hold-off
  localparam int    RAND_CHARS   = 200;
  localparam int    CLOSE_GROUPS = 8;     // full groups in the closing message
  localparam string B64_ALPHA   =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             last;
  } result_t;

  // One directed character; typed rows carry their own expectation
  typedef struct packed {
    logic [7:0]       ch;
    logic             st;
    logic             typed;
    logic             has_res;
    kind_e            kind;
    logic [LEN_W-1:0] len;
  } row_t;

  localparam row_t DIR_ROWS [25] = '{
    '{"A",      1'b0, 1'b1, 1'b0, KIND_DATA, 16'd0},  // ignored after reset
    '{CH_LF,    1'b1, 1'b1, 1'b1, KIND_DONE, 16'd0},  // empty message
    '{CH_NUL,   1'b1, 1'b1, 1'b1, KIND_ERR,  16'd0},  // NUL before any group
    '{CH_PLUS,  1'b1, 1'b1, 1'b0, KIND_DATA, 16'd0},  // "+ " prefix
    '{CH_SPACE, 1'b0, 1'b1, 1'b0, KIND_DATA, 16'd0},
    '{"T",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{"W",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{"F",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{"u",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{"b",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{"3",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{"I",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{CH_PAD,   1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},  // pad in fourth place
    '{CH_PLUS,  1'b1, 1'b1, 1'b0, KIND_DATA, 16'd0},  // '+' that is data
    '{"/",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{CH_PAD,   1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},  // pad, then a digit
    '{"w",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{"/",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},  // all-ones group
    '{"/",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{"/",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{"/",      1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{CH_NUL,   1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0},  // NUL ends message
    '{"Q",      1'b1, 1'b0, 1'b0, KIND_DATA, 16'd0},
    '{"Q",      1'b1, 1'b0, 1'b0, KIND_DATA, 16'd0},  // restart mid-group
    '{8'hFF,    1'b0, 1'b1, 1'b1, KIND_ERR,  16'd0}
  };

  logic clk_i;
  logic rst_ni;

  b64d_in_if  in_bus ();
  b64d_out_if out_bus ();

  base64_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Decoder model state
  logic [1:0]       grp_pos;
  logic [5:0]       held [3];
  bit               pad3;
  phase_e           prefix_st;
  bit               first_grp;
  bit               halted;
  logic [LEN_W-1:0] nbytes;

  result_t char_res [$];     // results of the latest character
  result_t pending_res [$];  // results still owed by the block

  bit src_idle_on;
  bit sink_idle_on;
  bit hold_off_req;
  int err_cnt;
  int chars_in;
  int live_cnt;
  int bytes_out;
  int dones_out;
  int errs_out;
  int quiet_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- decoder model ----------------

  function automatic bit alpha_index(input logic [7:0] c, output logic [5:0] v);
    v = '0;
    for (int i = 0; i < 64; i++) begin
      if (B64_ALPHA[i] == c) begin
        v = 6'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] rand_digit();
    return B64_ALPHA[$urandom_range(0, 63)];
  endfunction

  function automatic void clear_msg();
    grp_pos   = '0;
    held[0]   = '0;
    held[1]   = '0;
    held[2]   = '0;
    pad3      = 1'b0;
    prefix_st = PH_START;
    first_grp = 1'b1;
    nbytes    = '0;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    char_res.push_back(result_t'{KIND_DATA, b, 16'd0, 1'b0});
    if (nbytes != LEN_MAX) nbytes++;
  endfunction

  function automatic void end_message(kind_e k);
    char_res.push_back(result_t'{k, 8'h00, (k == KIND_DONE) ? nbytes : 16'd0, 1'b0});
    halted = 1'b1;
  endfunction

  // One character at the current place in the group of four
  function automatic void take_in_group(logic [7:0] c);
    logic [5:0] v;
    bit         ok;
    bit         pad4;
    ok = alpha_index(c, v);
    case (grp_pos)
      2'd0: begin
        if (c == CH_LF || (c == CH_NUL && !first_grp)) end_message(KIND_DONE);
        else if (!ok) end_message(KIND_ERR);
        else begin
          held[0] = v;
          grp_pos = 2'd1;
        end
      end
      2'd1: begin
        if (!ok) end_message(KIND_ERR);
        else begin
          held[1] = v;
          grp_pos = 2'd2;
        end
      end
      2'd2: begin
        if (c == CH_PAD) begin
          pad3    = 1'b1;
          held[2] = '0;
          grp_pos = 2'd3;
        end else if (!ok) end_message(KIND_ERR);
        else begin
          pad3    = 1'b0;
          held[2] = v;
          grp_pos = 2'd3;
        end
      end
      default: begin
        pad4 = (c == CH_PAD);
        if (!pad4 && !ok) end_message(KIND_ERR);
        else begin
          add_byte({held[0], held[1][5:4]});
          if (!pad3) begin
            add_byte({held[1][3:0], held[2][5:2]});
            if (!pad4) add_byte({held[2][1:0], v});
          end
          grp_pos   = '0;
          pad3      = 1'b0;
          first_grp = 1'b0;
          if (pad4) end_message(KIND_DONE);
        end
      end
    endcase
  endfunction

  // Results of one accepted character, into char_res
  function automatic void decode_char(logic [7:0] c, logic s);
    char_res.delete();
    if (s) begin
      clear_msg();
      halted = 1'b0;
    end
    if (halted) return;
    live_cnt++;
    case (prefix_st)
      PH_START: begin
        if (c == CH_PLUS) begin
          prefix_st = PH_PLUS;
          return;
        end
        prefix_st = PH_BODY;
        take_in_group(c);
      end
      PH_PLUS: begin
        prefix_st = PH_BODY;
        if (c == CH_SPACE) return;
        held[0] = DIGIT_PLUS;
        grp_pos = 2'd1;
        take_in_group(c);
      end
      default: take_in_group(c);
    endcase
    if (char_res.size() > 0) char_res[char_res.size()-1].last = 1'b1;
  endfunction

  // ---------------- source side ----------------

  task automatic drive_char(input logic [7:0] c, input logic s, input bit typed);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.char_code <= c;
    in_bus.start_req <= s;
    do @(posedge clk_i); while (!in_bus.ready);
    chars_in++;
    decode_char(c, s);
    if (!typed) foreach (char_res[k]) pending_res.push_back(char_res[k]);
  endtask

  // Drop valid and wait for every owed result; always waits on the clock
  task automatic drain_out();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_res.size() != 0);
  endtask

  // A random message: mostly well formed, sometimes broken or cut short
  task automatic send_message();
    logic [7:0] msg [$];
    int         ngroups;
    case ($urandom_range(0, 7))
      0: begin
        msg.push_back(CH_PLUS);
        msg.push_back(CH_SPACE);
      end
      1: begin
        msg.push_back(CH_PLUS);
        repeat (3) msg.push_back(rand_digit());
      end
      default: ;
    endcase
    ngroups = $urandom_range(0, 5);
    repeat (ngroups) begin
      msg.push_back(rand_digit());
      msg.push_back(rand_digit());
      msg.push_back(($urandom_range(0, 7) == 0) ? CH_PAD : rand_digit());
      msg.push_back(rand_digit());
    end
    case ($urandom_range(0, 9))
      0, 1, 2: msg.push_back(CH_LF);
      3, 4:    msg.push_back(CH_NUL);
      5: begin
        repeat (2) msg.push_back(rand_digit());
        repeat (2) msg.push_back(CH_PAD);
      end
      6: begin
        repeat (3) msg.push_back(rand_digit());
        msg.push_back(CH_PAD);
      end
      7: begin
        // stray byte somewhere in the message
        msg.insert($urandom_range(0, msg.size()), 8'($urandom_range(0, 255)));
        msg.push_back(CH_LF);
      end
      8: ;  // cut short, the next start abandons it
      default: begin
        // pad too early in a group
        if ($urandom_range(0, 1)) msg.push_back(rand_digit());
        msg.push_back(CH_PAD);
      end
    endcase
    if (msg.size() == 0) msg.push_back(CH_LF);
    foreach (msg[i]) drive_char(msg[i], i == 0, 1'b0);
    // trailing junk, mostly dropped while halted
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3))
        drive_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0, 1'b0);
    end
  endtask

  // ---------------- sink side ----------------

  initial begin : sink_proc
    int gap;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 12);
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // ---------------- result check ----------------

  always @(posedge clk_i) begin : result_chk
    result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      case (out_bus.kind)
        KIND_DATA: bytes_out++;
        KIND_DONE: dones_out++;
        default:   errs_out++;
      endcase
      if (pending_res.size() == 0) begin
        $error("unexpected beat: kind %0d data %02h length %0d last %0b",
               out_bus.kind, out_bus.data_byte, out_bus.length, out_bus.last);
        err_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (out_bus.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_bus.kind);
          err_cnt++;
        end
        if (out_bus.data_byte !== want.data) begin
          $error("data_byte: expected %02h, got %02h", want.data, out_bus.data_byte);
          err_cnt++;
        end
        if (out_bus.length !== want.len) begin
          $error("length: expected %0d, got %0d", want.len, out_bus.length);
          err_cnt++;
        end
        if (out_bus.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_bus.last);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without a beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_base64_decoder: done, errors");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------

  initial begin : stim
    int  rand_base;
    bit  hold_done;
    bit  pause_done;
    row_t r;
    err_cnt      = 0;
    chars_in     = 0;
    live_cnt     = 0;
    bytes_out    = 0;
    dones_out    = 0;
    errs_out     = 0;
    quiet_cycles = 0;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_off_req = 1'b0;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    clear_msg();
    halted = 1'b1;
    in_bus.valid     <= 1'b0;
    in_bus.char_code <= '0;
    in_bus.start_req <= 1'b0;
    rst_ni           <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < 25; i++) begin
      r = DIR_ROWS[i];
      drive_char(r.ch, r.st, r.typed);
      if (r.typed && r.has_res)
        pending_res.push_back(result_t'{r.kind, 8'h00, r.len, 1'b1});
    end
    drain_out();

    // Random messages with gaps on both sides
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    rand_base    = live_cnt;
    while (live_cnt - rand_base < RAND_CHARS) begin
      if (!hold_done && live_cnt - rand_base >= 60) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && live_cnt - rand_base >= 140) begin
        drain_out();
        pause_done = 1'b1;
      end
      send_message();
    end

    // Closing stretch without gaps: one message of full groups
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    drive_char(rand_digit(), 1'b1, 1'b0);
    repeat (3) drive_char(rand_digit(), 1'b0, 1'b0);
    repeat (CLOSE_GROUPS - 1) begin
      repeat (4) drive_char(rand_digit(), 1'b0, 1'b0);
    end
    drive_char(CH_LF, 1'b0, 1'b0);

    drain_out();
    repeat (10) @(posedge clk_i);
    if (pending_res.size() != 0) begin
      $error("%0d expected beats never arrived", pending_res.size());
      err_cnt++;
    end

    $display("Run covered %0d characters: %0d data bytes, %0d message ends, %0d errors,",
             chars_in, bytes_out, dones_out, errs_out);
    $display("with random gaps, a long sink hold-off and a gap-free closing message.");
    if (err_cnt == 0) begin
      $display("tb_base64_decoder: done, clean");
    end else begin
      $display("tb_base64_decoder: done, errors");
    end
    $finish;
  end

endmodule
